// ----- rtl/core/button_press_classifier_core_defines.svh -----
// Assertion macros used by the button press classifier RTL.
`ifndef BUTTON_PRESS_CLASSIFIER_CORE_DEFINES_SVH
`define BUTTON_PRESS_CLASSIFIER_CORE_DEFINES_SVH

// Checks that a condition implies another condition in the same cycle.
`define BPC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that a condition implies another condition in the next cycle.
`define BPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/bpc_pkg.sv -----
// Types and constants of the button press classifier.
`default_nettype none
package bpc_pkg;

  localparam int BUTTONS = 2;
  localparam int MASK_W  = 2;
  localparam int EXT_W   = (BUTTONS > MASK_W) ? BUTTONS : MASK_W;
  localparam int CNT_W   = 8;
  localparam int CFG_W   = 8;
  localparam int IDX_W   = 2;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic [IDX_W-1:0] REG_SHORT   = 2'd0;
  localparam logic [IDX_W-1:0] REG_LONG    = 2'd1;
  localparam logic [IDX_W-1:0] REG_RELEASE = 2'd2;

  localparam logic [CFG_W-1:0] SHORT_RST   = 8'd2;
  localparam logic [CFG_W-1:0] LONG_RST    = 8'd50;
  localparam logic [CFG_W-1:0] RELEASE_RST = 8'd2;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_FIRST = 2'd1,
    PH_HOLD  = 2'd2,
    PH_REL   = 2'd3
  } phase_t;

  typedef struct packed {
    logic [MASK_W-1:0] short_mask;
    logic [MASK_W-1:0] long_mask;
  } result_t;

endpackage
`default_nettype wire

// ----- rtl/core/button_press_classifier_core.sv -----
// Top level of the button press classifier: per-button press state and output skid buffer.
// Each accepted word is one scan tick carrying the sampled level of every button, and each
// tick yields exactly one result word with a short-press and a long-press mask. The block
// takes one tick per clock cycle when not stalled: the per-button phase and saturating tick
// counter are registered on each accepted tick, and a two-word output buffer lets a new tick
// enter while one result waits on the output, so the input stalls only when both output
// slots are full. A result reaches the output in the cycle after its tick is accepted when
// no earlier result is held by a stall. The user must write the thresholds through the
// configuration port while no tick is in flight; the block itself does not enforce this.
`default_nettype none
`include "button_press_classifier_core_defines.svh"
module button_press_classifier_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [bpc_pkg::MASK_W-1:0]    in_pressed_mask,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [bpc_pkg::MASK_W-1:0]    out_short_mask,
  output logic      [bpc_pkg::MASK_W-1:0]    out_long_mask,
  input  wire logic                          cfg_we,
  input  wire logic [bpc_pkg::IDX_W-1:0]     cfg_index,
  input  wire logic [bpc_pkg::CFG_W-1:0]     cfg_data
);

  logic [bpc_pkg::CFG_W-1:0] short_ticks_r;
  logic [bpc_pkg::CFG_W-1:0] long_ticks_r;
  logic [bpc_pkg::CFG_W-1:0] release_ticks_r;

  bpc_pkg::phase_t           phase_r   [bpc_pkg::BUTTONS];
  bpc_pkg::phase_t           phase_nxt [bpc_pkg::BUTTONS];
  logic [bpc_pkg::CNT_W-1:0] count_r   [bpc_pkg::BUTTONS];
  logic [bpc_pkg::CNT_W-1:0] count_nxt [bpc_pkg::BUTTONS];
  logic [bpc_pkg::CNT_W-1:0] count_inc [bpc_pkg::BUTTONS];
  logic [bpc_pkg::BUTTONS-1:0] moved;

  logic [bpc_pkg::EXT_W-1:0] pressed_ext;
  logic [bpc_pkg::EXT_W-1:0] short_ev;
  logic [bpc_pkg::EXT_W-1:0] long_ev;
  bpc_pkg::result_t          result;

  bpc_pkg::result_t          head_r;
  bpc_pkg::result_t          skid_r;
  logic                      head_vld_r;
  logic                      skid_vld_r;
  logic                      push;
  logic                      pop;

  assign in_stall       = skid_vld_r;
  assign out_valid      = head_vld_r;
  assign out_short_mask = head_r.short_mask;
  assign out_long_mask  = head_r.long_mask;
  assign push           = in_valid && !in_stall;
  assign pop            = head_vld_r && !out_stall;
  assign pressed_ext    = bpc_pkg::EXT_W'(in_pressed_mask);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_ticks_r   <= bpc_pkg::SHORT_RST;
      long_ticks_r    <= bpc_pkg::LONG_RST;
      release_ticks_r <= bpc_pkg::RELEASE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        bpc_pkg::REG_SHORT:   short_ticks_r   <= cfg_data;
        bpc_pkg::REG_LONG:    long_ticks_r    <= cfg_data;
        bpc_pkg::REG_RELEASE: release_ticks_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // The counter saturates at its maximum value.
  always_comb begin
    for (int b = 0; b < bpc_pkg::BUTTONS; b++) begin
      moved[b]     = (count_r[b] != bpc_pkg::CNT_MAX);
      count_inc[b] = moved[b] ? count_r[b] + 1'b1 : count_r[b];
    end
  end

  always_comb begin
    for (int b = 0; b < bpc_pkg::BUTTONS; b++) begin
      phase_nxt[b] = phase_r[b];
      count_nxt[b] = count_r[b];
      case (phase_r[b])
        bpc_pkg::PH_IDLE: begin
          if (pressed_ext[b]) begin
            phase_nxt[b] = bpc_pkg::PH_FIRST;
            count_nxt[b] = '0;
          end
        end
        bpc_pkg::PH_FIRST: begin
          count_nxt[b] = count_inc[b];
          if (pressed_ext[b]) begin
            if (count_inc[b] >= short_ticks_r) begin
              phase_nxt[b] = bpc_pkg::PH_HOLD;
              count_nxt[b] = '0;
            end
          end else begin
            phase_nxt[b] = bpc_pkg::PH_IDLE;
          end
        end
        bpc_pkg::PH_HOLD: begin
          count_nxt[b] = count_inc[b];
          if (!pressed_ext[b]) begin
            phase_nxt[b] = bpc_pkg::PH_REL;
            count_nxt[b] = '0;
          end
        end
        bpc_pkg::PH_REL: begin
          if (pressed_ext[b]) begin
            count_nxt[b] = '0;
          end else begin
            count_nxt[b] = count_inc[b];
            if (count_inc[b] >= release_ticks_r) begin
              phase_nxt[b] = bpc_pkg::PH_IDLE;
            end
          end
        end
        default: begin
          phase_nxt[b] = bpc_pkg::PH_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    short_ev = '0;
    long_ev  = '0;
    for (int b = 0; b < bpc_pkg::BUTTONS; b++) begin
      if (phase_r[b] == bpc_pkg::PH_HOLD) begin
        if (pressed_ext[b]) begin
          long_ev[b] = moved[b] && (count_inc[b] == long_ticks_r);
        end else begin
          short_ev[b] = (count_inc[b] < long_ticks_r);
        end
      end
    end
    result.short_mask = short_ev[bpc_pkg::MASK_W-1:0];
    result.long_mask  = long_ev[bpc_pkg::MASK_W-1:0];
  end

  always_ff @(posedge clk) begin
    for (int b = 0; b < bpc_pkg::BUTTONS; b++) begin
      if (!rst_n) begin
        phase_r[b] <= bpc_pkg::PH_IDLE;
        count_r[b] <= '0;
      end else if (push) begin
        phase_r[b] <= phase_nxt[b];
        count_r[b] <= count_nxt[b];
      end
    end
  end

  // Two-word output buffer: the head drives the output, the skid slot absorbs one stall.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (pop && skid_vld_r) begin
      head_r <= skid_r;
      if (push) begin
        skid_r <= result;
      end else begin
        skid_vld_r <= 1'b0;
      end
    end else if (pop || !head_vld_r) begin
      head_vld_r <= push;
      head_r     <= result;
    end else if (push) begin
      skid_vld_r <= 1'b1;
      skid_r     <= result;
    end
  end

  `BPC_ASSERT_NOW(a_skid_needs_head, clk, rst_n, skid_vld_r, head_vld_r,
                  "skid word without head word")
  `BPC_ASSERT_NOW(a_one_event_per_button, clk, rst_n, head_vld_r,
                  (head_r.short_mask & head_r.long_mask) == '0,
                  "short and long event on one button")
  `BPC_ASSERT_NEXT(a_idle_stays_up, clk, rst_n,
                   push && !pressed_ext[0] && (phase_r[0] == bpc_pkg::PH_IDLE),
                   phase_r[0] == bpc_pkg::PH_IDLE, "idle button left idle while released")

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for the button press classifier core with a press-event scoreboard.
`timescale 1ns / 100ps
module tb_top;

  localparam logic [bpc_pkg::IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 4000;
  localparam int N_PLAN = 6;
  localparam int N_DIRECTED = 20;

  class press_scoreboard;
    logic [bpc_pkg::CFG_W-1:0] short_ticks;
    logic [bpc_pkg::CFG_W-1:0] long_ticks;
    logic [bpc_pkg::CFG_W-1:0] release_ticks;
    bpc_pkg::phase_t           phase [bpc_pkg::BUTTONS];
    logic [bpc_pkg::CNT_W-1:0] count [bpc_pkg::BUTTONS];
    bpc_pkg::result_t          expected_events [$];
    int                        errors;

    function new();
      short_ticks   = bpc_pkg::SHORT_RST;
      long_ticks    = bpc_pkg::LONG_RST;
      release_ticks = bpc_pkg::RELEASE_RST;
      for (int b = 0; b < bpc_pkg::BUTTONS; b++) begin
        phase[b] = bpc_pkg::PH_IDLE;
        count[b] = '0;
      end
      errors = 0;
    endfunction

    function void set_reg(logic [bpc_pkg::IDX_W-1:0] idx, logic [bpc_pkg::CFG_W-1:0] val);
      case (idx)
        bpc_pkg::REG_SHORT: begin
          short_ticks = val;
        end
        bpc_pkg::REG_LONG: begin
          long_ticks = val;
        end
        bpc_pkg::REG_RELEASE: begin
          release_ticks = val;
        end
        default: begin
        end
      endcase
    endfunction

    function bit bump(int b);
      if (count[b] == bpc_pkg::CNT_MAX) return 1'b0;
      count[b] = count[b] + 1'b1;
      return 1'b1;
    endfunction

    function void note_tick(logic [bpc_pkg::MASK_W-1:0] mask);
      bpc_pkg::result_t r;
      bit               down;
      bit               moved;
      r = '0;
      for (int b = 0; b < bpc_pkg::BUTTONS; b++) begin
        down = (b < bpc_pkg::MASK_W) ? mask[b] : 1'b0;
        case (phase[b])
          bpc_pkg::PH_IDLE: begin
            if (down) begin
              phase[b] = bpc_pkg::PH_FIRST;
              count[b] = '0;
            end
          end
          bpc_pkg::PH_FIRST: begin
            void'(bump(b));
            if (!down) begin
              phase[b] = bpc_pkg::PH_IDLE;
            end else if (count[b] >= short_ticks) begin
              phase[b] = bpc_pkg::PH_HOLD;
              count[b] = '0;
            end
          end
          bpc_pkg::PH_HOLD: begin
            moved = bump(b);
            if (down) begin
              if (moved && count[b] == long_ticks && b < bpc_pkg::MASK_W)
                r.long_mask[b] = 1'b1;
            end else begin
              if (count[b] < long_ticks && b < bpc_pkg::MASK_W) r.short_mask[b] = 1'b1;
              count[b] = '0;
              phase[b] = bpc_pkg::PH_REL;
            end
          end
          default: begin
            if (down) begin
              count[b] = '0;
            end else begin
              void'(bump(b));
              if (count[b] >= release_ticks) phase[b] = bpc_pkg::PH_IDLE;
            end
          end
        endcase
      end
      expected_events.push_back(r);
    endfunction

    function void check_result(logic [bpc_pkg::MASK_W-1:0] short_mask,
                               logic [bpc_pkg::MASK_W-1:0] long_mask);
      bpc_pkg::result_t e;
      if (expected_events.size() == 0) begin
        $error("unexpected result word: short_mask %0d long_mask %0d", short_mask, long_mask);
        errors++;
        return;
      end
      e = expected_events.pop_front();
      if (short_mask !== e.short_mask) begin
        $error("short_mask: expected %0d, actual %0d", e.short_mask, short_mask);
        errors++;
      end
      if (long_mask !== e.long_mask) begin
        $error("long_mask: expected %0d, actual %0d", e.long_mask, long_mask);
        errors++;
      end
    endfunction

    function int pending();
      return expected_events.size();
    endfunction
  endclass

  logic                        clk;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [bpc_pkg::MASK_W-1:0]  in_pressed_mask = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [bpc_pkg::MASK_W-1:0]  out_short_mask;
  logic [bpc_pkg::MASK_W-1:0]  out_long_mask;
  logic                        cfg_we = 1'b0;
  logic [bpc_pkg::IDX_W-1:0]   cfg_index = '0;
  logic [bpc_pkg::CFG_W-1:0]   cfg_data = '0;

  press_scoreboard sb = new();
  int idle_mode = 0;
  int quiet = 0;

  button_press_classifier_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_pressed_mask (in_pressed_mask),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_short_mask  (out_short_mask),
    .out_long_mask   (out_long_mask),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      case (idle_mode)
        2: out_stall <= ($urandom_range(0, 99) < 78);
        3: out_stall <= ($urandom_range(0, 99) < 13);
        default: out_stall <= 1'b0;
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_tick(in_pressed_mask);
    if (rst_n && out_valid && !out_stall) sb.check_result(out_short_mask, out_long_mask);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
        quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
        $display("status: fail");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  task automatic send_tick(input logic [bpc_pkg::MASK_W-1:0] mask);
    @(negedge clk);
    while ((idle_mode == 1 && $urandom_range(0, 99) < 78) ||
           (idle_mode == 3 && $urandom_range(0, 99) < 13)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_pressed_mask <= mask;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_reg(input logic [bpc_pkg::IDX_W-1:0] idx,
                           input logic [bpc_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    logic [bpc_pkg::MASK_W-1:0] directed [N_DIRECTED];
    int plan_short  [N_PLAN];
    int plan_long   [N_PLAN];
    int plan_rel    [N_PLAN];
    int plan_budget [N_PLAN];
    bit level [bpc_pkg::BUTTONS];
    int run_left [bpc_pkg::BUTTONS];
    logic [bpc_pkg::MASK_W-1:0] mask;
    int s;
    int l;
    int r;
    int pick;

    directed = '{
      2'b00, 2'b11, 2'b11, 2'b11, 2'b00, 2'b00, 2'b00, 2'b01, 2'b01, 2'b01,
      2'b10, 2'b10, 2'b11, 2'b01, 2'b00, 2'b01, 2'b00, 2'b00, 2'b11, 2'b00
    };
    plan_short  = '{2, 1, 0, 3, 255, 1};
    plan_long   = '{50, 1, 0, 8, 254, 255};
    plan_rel    = '{2, 1, 0, 2, 255, 1};
    plan_budget = '{300, 200, 150, 300, 600, 300};
    for (int b = 0; b < bpc_pkg::BUTTONS; b++) begin
      level[b]    = 1'b0;
      run_left[b] = 0;
    end
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIRECTED; i++) send_tick(directed[i]);
    drain();

    for (int k = 0; k < N_PLAN; k++) begin
      if (k > 0) begin
        write_reg(bpc_pkg::REG_SHORT, bpc_pkg::CFG_W'(plan_short[k]));
        write_reg(bpc_pkg::REG_LONG, bpc_pkg::CFG_W'(plan_long[k]));
        write_reg(bpc_pkg::REG_RELEASE, bpc_pkg::CFG_W'(plan_rel[k]));
        write_reg(REG_UNUSED, bpc_pkg::CFG_W'($urandom_range(0, 255)));
      end
      s = (plan_short[k] == 0) ? 1 : plan_short[k];
      l = plan_long[k];
      r = (plan_rel[k] == 0) ? 1 : plan_rel[k];
      for (int i = 0; i < plan_budget[k]; i++) begin
        idle_mode = (i * 4 / plan_budget[k] + k) % 4;
        mask = '0;
        for (int b = 0; b < bpc_pkg::BUTTONS; b++) begin
          if (run_left[b] <= 0) begin
            level[b] = !level[b];
            pick = $urandom_range(0, 9);
            if (level[b]) begin
              case (pick)
                0: run_left[b] = $urandom_range(1, 3);
                1, 2: run_left[b] = s + $urandom_range(0, 2);
                3, 4: run_left[b] = s + l + $urandom_range(0, 2);
                5: run_left[b] = s + l + $urandom_range(3, 12);
                default: run_left[b] = $urandom_range(1, s + l / 2 + 2);
              endcase
            end else begin
              case (pick)
                0, 1: run_left[b] = $urandom_range(1, 2);
                2, 3, 4, 5: run_left[b] = r - 1 + $urandom_range(0, 2);
                default: run_left[b] = $urandom_range(1, r + 5);
              endcase
              if (run_left[b] < 1) run_left[b] = 1;
            end
          end
          if (b < bpc_pkg::MASK_W) mask[b] = level[b];
          run_left[b]--;
        end
        if ($urandom_range(0, 19) == 0)
          mask = bpc_pkg::MASK_W'($urandom_range(0, (1 << bpc_pkg::MASK_W) - 1));
        send_tick(mask);
      end
      idle_mode = 0;
      drain();
    end

    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
